### src/c_integer_literal_parser_macros.svh
// ----------------------------------------------------------------------------
// C integer literal parser assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef C_INTEGER_LITERAL_PARSER_MACROS_SVH
`define C_INTEGER_LITERAL_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CILP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cilp assertion failed");

// Next-cycle implication, checked outside reset
`define CILP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cilp assertion failed");

`endif

### src/cilp_pkg.sv
// ----------------------------------------------------------------------------
// C integer literal parser package
// Item types, parse phases and the parser state record.
// ----------------------------------------------------------------------------
`default_nettype none

package cilp_pkg;

  // One character of the text
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  // One parse result
  typedef struct packed {
    logic signed [31:0] value;
    logic               valid_res;
  } out_t;

  // Parse phase
  typedef enum logic [3:0] {
    PH_SKIP     = 4'd0,
    PH_SIGNED   = 4'd1,
    PH_ZERO     = 4'd2,
    PH_OCT      = 4'd3,
    PH_DEC      = 4'd4,
    PH_HEXSTART = 4'd5,
    PH_HEX      = 4'd6,
    PH_DONE_OK  = 4'd7,
    PH_DONE_BAD = 4'd8
  } phase_e;

  // Parser state carried from character to character
  typedef struct packed {
    phase_e      phase;
    logic        negative;
    logic [31:0] accum;
  } st_t;

  localparam logic [7:0] ChBlank = 8'h20;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;

endpackage

`default_nettype wire

### src/cilp_in_stage.sv
// ----------------------------------------------------------------------------
// C integer literal parser input stage
// Registers one incoming item and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cilp_in_stage (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  cilp_pkg::in_t  in_data_i,
  input  wire            take_i,
  output logic           vld_o,
  output cilp_pkg::in_t  data_o
);

  logic          vld_q, vld_d;
  cilp_pkg::in_t data_q;

  // Stall while a held item is not taken
  assign in_stall_o = vld_q && !take_i;
  assign vld_d      = in_stall_o ? vld_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Load the payload on an accepted item
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= in_data_i;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

### src/cilp_step.sv
// ----------------------------------------------------------------------------
// C integer literal parser step logic
// Next parser state for one character, plus the literal-recognized flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cilp_step (
  input  cilp_pkg::st_t cur_i,
  input  wire [7:0]     ch_i,
  output cilp_pkg::st_t nxt_o,
  output logic          ok_o
);

  logic        is_dec, is_oct, is_hex, is_blank;
  logic [3:0]  hex_dig;
  logic [31:0] dig, acc8, acc10, acc16;

  // Classify the character
  assign is_dec   = (ch_i >= cilp_pkg::ChZero) && (ch_i <= cilp_pkg::ChNine);
  assign is_oct   = (ch_i >= cilp_pkg::ChZero) && (ch_i <= cilp_pkg::ChSeven);
  assign is_hex   = is_dec
                 || ((ch_i >= cilp_pkg::ChUpA) && (ch_i <= cilp_pkg::ChUpF))
                 || ((ch_i >= cilp_pkg::ChLowA) && (ch_i <= cilp_pkg::ChLowF));
  assign is_blank = (ch_i != 8'h00) && (ch_i <= cilp_pkg::ChBlank);

  // Letters a..f carry 1..6 in the low nibble
  assign hex_dig = ch_i[6] ? (ch_i[3:0] + 4'd9) : ch_i[3:0];
  assign dig     = {28'd0, hex_dig};

  // Shift-add scaling of the accumulator
  assign acc8  = {cur_i.accum[28:0], 3'b000};
  assign acc16 = {cur_i.accum[27:0], 4'b0000};
  assign acc10 = acc8 + {cur_i.accum[30:0], 1'b0};

  always_comb begin
    nxt_o = cur_i;
    unique case (cur_i.phase) inside
      cilp_pkg::PH_SKIP, cilp_pkg::PH_SIGNED: begin
        if ((cur_i.phase == cilp_pkg::PH_SKIP) && is_blank) begin
          nxt_o.phase = cilp_pkg::PH_SKIP;
        end else if ((cur_i.phase == cilp_pkg::PH_SKIP) && (ch_i == cilp_pkg::ChMinus)) begin
          nxt_o.negative = 1'b1;
          nxt_o.phase    = cilp_pkg::PH_SIGNED;
        end else if ((cur_i.phase == cilp_pkg::PH_SKIP) && (ch_i == cilp_pkg::ChPlus)) begin
          nxt_o.phase = cilp_pkg::PH_SIGNED;
        end else if (ch_i == cilp_pkg::ChZero) begin
          nxt_o.accum = 32'd0;
          nxt_o.phase = cilp_pkg::PH_ZERO;
        end else if (is_dec) begin
          nxt_o.accum = dig;
          nxt_o.phase = cilp_pkg::PH_DEC;
        end else begin
          nxt_o.phase = cilp_pkg::PH_DONE_BAD;
        end
      end
      cilp_pkg::PH_ZERO: begin
        if (ch_i == cilp_pkg::ChLowX) begin
          nxt_o.phase = cilp_pkg::PH_HEXSTART;
        end else if (is_oct) begin
          nxt_o.accum = acc8 + dig;
          nxt_o.phase = cilp_pkg::PH_OCT;
        end else begin
          nxt_o.phase = cilp_pkg::PH_DONE_OK;
        end
      end
      cilp_pkg::PH_OCT: begin
        if (is_oct) begin
          nxt_o.accum = acc8 + dig;
        end else begin
          nxt_o.phase = cilp_pkg::PH_DONE_OK;
        end
      end
      cilp_pkg::PH_DEC: begin
        if (is_dec) begin
          nxt_o.accum = acc10 + dig;
        end else begin
          nxt_o.phase = cilp_pkg::PH_DONE_OK;
        end
      end
      cilp_pkg::PH_HEXSTART: begin
        if (is_hex) begin
          nxt_o.accum = dig;
          nxt_o.phase = cilp_pkg::PH_HEX;
        end else begin
          nxt_o.phase = cilp_pkg::PH_DONE_BAD;
        end
      end
      cilp_pkg::PH_HEX: begin
        if (is_hex) begin
          nxt_o.accum = acc16 + dig;
        end else begin
          nxt_o.phase = cilp_pkg::PH_DONE_OK;
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

  // A literal stands once a digit has been taken
  assign ok_o = nxt_o.phase inside {cilp_pkg::PH_ZERO, cilp_pkg::PH_OCT, cilp_pkg::PH_DEC,
                                    cilp_pkg::PH_HEX, cilp_pkg::PH_DONE_OK};

endmodule

`default_nettype wire

### src/c_integer_literal_parser.sv
// A string's last item passes the input register, then the result register.
// Throughput: one character item per cycle when the output is not stalled;
//   one shift-add per character updates the state between the two registers.
// Reset: asynchronous, active low; clears the parse state to whitespace
//   skipping and empties the input and result registers.
// ----------------------------------------------------------------------------
// C integer literal parser
// Parses a C integer literal from a character stream, one result per string.
// ----------------------------------------------------------------------------
`default_nettype none

module c_integer_literal_parser (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  cilp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output cilp_pkg::out_t out_data_o
);

  logic          stg_vld, take, ok;
  cilp_pkg::in_t stg_data;
  cilp_pkg::st_t st_q, st_nxt;

  logic          out_vld_q;
  logic          neg_q;
  logic          ok_q;
  logic [31:0]   acc_q;

  cilp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .vld_o      (stg_vld),
    .data_o     (stg_data)
  );

  cilp_step u_step (
    .cur_i (st_q),
    .ch_i  (stg_data.ch),
    .nxt_o (st_nxt),
    .ok_o  (ok)
  );

  // Take the held item when the result register can accept
  assign take = stg_vld && (!out_vld_q || !out_stall_i);

  // Advance parse state; restart after the last item of a string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: cilp_pkg::PH_SKIP, negative: 1'b0, accum: 32'd0};
    end else if (take) begin
      if (stg_data.last) begin
        st_q <= '{phase: cilp_pkg::PH_SKIP, negative: 1'b0, accum: 32'd0};
      end else begin
        st_q <= st_nxt;
      end
    end
  end

  // Result valid: set on a finished string, hold while stalled, else drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= (take && stg_data.last) || (out_vld_q && out_stall_i);
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (take && stg_data.last) begin
      ok_q  <= ok;
      neg_q <= st_nxt.negative;
      acc_q <= ok ? st_nxt.accum : 32'd0;
    end
  end

  // Apply the sign on the way out
  assign out_valid_o          = out_vld_q;
  assign out_data_o.valid_res = ok_q;
  assign out_data_o.value     = neg_q ? (32'd0 - acc_q) : acc_q;

endmodule

`default_nettype wire

### src/cilp_checker.sv
// ----------------------------------------------------------------------------
// C integer literal parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_integer_literal_parser_macros.svh"

module cilp_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_stall_o,
  input wire            out_valid_o,
  input wire            out_stall_i,
  input cilp_pkg::out_t out_data_o
);

  // A stalled result stays
  `CILP_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result keeps its payload
  `CILP_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o))

  // A null result carries zero
  `CILP_ASSERT_IMP(a_null_zero, out_valid_o && !out_data_o.valid_res, out_data_o.value == '0)

  // Input never stalls while the result register is empty
  `CILP_ASSERT_IMP(a_no_idle_stall, !out_valid_o, !in_stall_o)

  // A new item is taken even under a waiting result once the output is free
  `CILP_ASSERT_NXT(a_stall_clears, in_stall_o && !out_stall_i, !in_stall_o || out_valid_o)

endmodule

bind c_integer_literal_parser cilp_checker u_cilp_checker (.*);

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// C integer literal parser testbench
// Feeds text strings one character per item through the valid/stall input
// channel, predicts each parse result in a scoreboard and checks every result
// that leaves the output channel, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam logic [7:0] ChNul = 8'h00;
  localparam int unsigned RandomItems = 450;
  localparam int unsigned HoldCycles = 300;

  // Predicts parse results and checks the ones that come out
  class literal_scoreboard;
    cilp_pkg::phase_e phase;
    logic             negative;
    logic [31:0]      accum;
    cilp_pkg::out_t   expected_q[$];
    int unsigned      errors;

    function new();
      clear_parse();
      errors = 0;
    endfunction

    function void clear_parse();
      phase    = cilp_pkg::PH_SKIP;
      negative = 1'b0;
      accum    = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [31:0] hex_digit(logic [7:0] c);
      if (c <= cilp_pkg::ChNine) begin
        return 32'(c - cilp_pkg::ChZero);
      end
      return 32'((c & ~cilp_pkg::ChBlank) - cilp_pkg::ChUpA) + 32'd10;
    endfunction

    function logic is_dec(logic [7:0] c);
      return c >= cilp_pkg::ChZero && c <= cilp_pkg::ChNine;
    endfunction

    function logic is_hex(logic [7:0] c);
      return is_dec(c) || (c >= cilp_pkg::ChUpA && c <= cilp_pkg::ChUpF)
          || (c >= cilp_pkg::ChLowA && c <= cilp_pkg::ChLowF);
    endfunction

    // Start a number, or give up if the byte is no digit
    function void take_first(logic [7:0] c);
      if (c == cilp_pkg::ChZero) begin
        accum = '0;
        phase = cilp_pkg::PH_ZERO;
      end else if (is_dec(c)) begin
        accum = 32'(c - cilp_pkg::ChZero);
        phase = cilp_pkg::PH_DEC;
      end else begin
        phase = cilp_pkg::PH_DONE_BAD;
      end
    endfunction

    // Advance the parse by one accepted character
    function void note_char(cilp_pkg::in_t item);
      logic [7:0]     c;
      cilp_pkg::out_t res;
      c = item.ch;
      case (phase)
        cilp_pkg::PH_SKIP: begin
          if (c != ChNul && c <= cilp_pkg::ChBlank) begin
            // leading blank, stay put
          end else if (c == cilp_pkg::ChMinus) begin
            negative = 1'b1;
            phase    = cilp_pkg::PH_SIGNED;
          end else if (c == cilp_pkg::ChPlus) begin
            phase = cilp_pkg::PH_SIGNED;
          end else begin
            take_first(c);
          end
        end
        cilp_pkg::PH_SIGNED: take_first(c);
        cilp_pkg::PH_ZERO: begin
          if (c == cilp_pkg::ChLowX) begin
            phase = cilp_pkg::PH_HEXSTART;
          end else if (c >= cilp_pkg::ChZero && c <= cilp_pkg::ChSeven) begin
            accum = accum * 8 + 32'(c - cilp_pkg::ChZero);
            phase = cilp_pkg::PH_OCT;
          end else begin
            phase = cilp_pkg::PH_DONE_OK;
          end
        end
        cilp_pkg::PH_OCT: begin
          if (c >= cilp_pkg::ChZero && c <= cilp_pkg::ChSeven) begin
            accum = accum * 8 + 32'(c - cilp_pkg::ChZero);
          end else begin
            phase = cilp_pkg::PH_DONE_OK;
          end
        end
        cilp_pkg::PH_DEC: begin
          if (is_dec(c)) begin
            accum = accum * 10 + 32'(c - cilp_pkg::ChZero);
          end else begin
            phase = cilp_pkg::PH_DONE_OK;
          end
        end
        cilp_pkg::PH_HEXSTART: begin
          if (is_hex(c)) begin
            accum = hex_digit(c);
            phase = cilp_pkg::PH_HEX;
          end else begin
            phase = cilp_pkg::PH_DONE_BAD;
          end
        end
        cilp_pkg::PH_HEX: begin
          if (is_hex(c)) begin
            accum = accum * 16 + hex_digit(c);
          end else begin
            phase = cilp_pkg::PH_DONE_OK;
          end
        end
        default: begin
        end
      endcase

      // Emit the result on the final character and start over
      if (item.last) begin
        res.valid_res = phase inside {cilp_pkg::PH_ZERO, cilp_pkg::PH_OCT, cilp_pkg::PH_DEC,
                                      cilp_pkg::PH_HEX, cilp_pkg::PH_DONE_OK};
        res.value     = '0;
        if (res.valid_res) begin
          res.value = negative ? (32'd0 - accum) : accum;
        end
        expected_q.push_back(res);
        clear_parse();
      end
    endfunction

    task report(string what);
      $display("%0t ns mismatch: %s", $time, what);
      errors++;
    endtask

    // Compare one result with the oldest expectation
    task check_result(cilp_pkg::out_t got);
      cilp_pkg::out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result value %0d valid %0b with nothing expected",
                         got.value, got.valid_res));
      end else begin
        want = expected_q.pop_front();
        if (got.value !== want.value) begin
          report($sformatf("value %0d, expected %0d", got.value, want.value));
        end
        if (got.valid_res !== want.valid_res) begin
          report($sformatf("valid_res %0b, expected %0b", got.valid_res, want.valid_res));
        end
      end
    endtask
  endclass

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  cilp_pkg::in_t  in_data_i   = '0;
  logic           out_stall_i = 1'b0;
  logic           in_stall_o;
  logic           out_valid_o;
  cilp_pkg::out_t out_data_o;

  literal_scoreboard sb = new();
  logic [7:0]        text_q[$];
  int unsigned       chars_sent = 0;
  logic              hold_asked = 1'b0;
  logic              hold_done  = 1'b0;

  c_integer_literal_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one character and hold it until it is taken
  task automatic send_char(cilp_pkg::in_t item, int unsigned gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_char(item);
    chars_sent++;
  endtask

  // Send the whole text buffer as one string
  task automatic send_text();
    cilp_pkg::in_t item;
    logic          steady;
    steady = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < text_q.size(); i++) begin
      item.ch   = text_q[i];
      item.last = (i == text_q.size() - 1);
      send_char(item, steady ? 0 : gap_len());
    end
  endtask

  // Drop valid and wait for every expected result
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Build a random string: mostly literals with random content, some noise
  task automatic build_text();
    int unsigned kind;
    int unsigned r;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(1, 32)));
    r = $urandom_range(0, 9);
    if (r < 3) text_q.push_back(cilp_pkg::ChMinus);
    else if (r < 5) text_q.push_back(cilp_pkg::ChPlus);
    if (r == 0) text_q.push_back($urandom_range(0, 1) ? cilp_pkg::ChMinus : cilp_pkg::ChPlus);
    case ($urandom_range(0, 2))
      0: begin
        text_q.push_back(8'(cilp_pkg::ChZero + $urandom_range(1, 9)));
        repeat ($urandom_range(0, 11))
          text_q.push_back(8'(cilp_pkg::ChZero + $urandom_range(0, 9)));
      end
      1: begin
        text_q.push_back(cilp_pkg::ChZero);
        repeat ($urandom_range(0, 12))
          text_q.push_back(8'(cilp_pkg::ChZero + $urandom_range(0, 7)));
      end
      default: begin
        text_q.push_back(cilp_pkg::ChZero);
        text_q.push_back(cilp_pkg::ChLowX);
        repeat ($urandom_range(0, 10)) begin
          r = $urandom_range(0, 21);
          if (r < 10) text_q.push_back(8'(cilp_pkg::ChZero + r));
          else if (r < 16) text_q.push_back(8'(cilp_pkg::ChLowA + r - 10));
          else text_q.push_back(8'(cilp_pkg::ChUpA + r - 16));
        end
      end
    endcase
    repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Check every result taken at the output
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_data_o);
    end
  end

  // Output side: random stalls, quiet stretches and one long hold
  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_asked && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        int unsigned n;
        n = gap_len();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(negedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 120)) @(negedge clk_i);
      else repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  // Main stimulus
  initial begin
    logic paused;
    paused = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings
    text_q = '{cilp_pkg::ChZero};
    send_text();
    text_q = '{cilp_pkg::ChMinus, cilp_pkg::ChPlus};
    send_text();
    text_q = '{cilp_pkg::ChZero, cilp_pkg::ChLowX};
    send_text();
    text_q = '{8'h01, cilp_pkg::ChMinus, cilp_pkg::ChZero, cilp_pkg::ChLowX,
               cilp_pkg::ChUpA, cilp_pkg::ChLowF};
    send_text();
    text_q = '{cilp_pkg::ChZero, cilp_pkg::ChSeven, 8'hFF};
    send_text();
    text_q = '{ChNul, cilp_pkg::ChSeven};
    send_text();
    text_q = '{cilp_pkg::ChNine, cilp_pkg::ChNine, cilp_pkg::ChNine, cilp_pkg::ChNine,
               cilp_pkg::ChNine, cilp_pkg::ChNine, cilp_pkg::ChNine, cilp_pkg::ChNine,
               cilp_pkg::ChNine, cilp_pkg::ChNine};
    send_text();
    drain_results();

    // Random strings
    while (chars_sent < RandomItems) begin
      build_text();
      send_text();
      if (!hold_asked && chars_sent > 150) hold_asked = 1'b1;
      if (!paused && chars_sent > 320) begin
        paused = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
